[sv/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, hash constants and round functions for the message hash.
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef logic [31:0] word_type;
   typedef word_type hash_type [8];
   typedef word_type sched_type [16];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUNDS,
      ST_FINAL,
      ST_PAD,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      PAD_NONE,
      PAD_MARK,
      PAD_ZERO,
      PAD_LEN_LO,
      PAD_DONE
   } pad_type;

   localparam word_type MARK_WORD = 32'h8000_0000;
   localparam logic [3:0] LEN_HI_POS = 4'd14;

   localparam hash_type INIT_HASH = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   // Keep the leading valid bytes of a final word and, when fewer than four are valid, place the marker after them
   function automatic word_type mark_word(input word_type data, input logic [2:0] nbytes);
      word_type res;
      unique case (nbytes)
         3'd0:    res = MARK_WORD;
         3'd1:    res = {data[31:24], 24'h80_0000};
         3'd2:    res = {data[31:16], 16'h8000};
         3'd3:    res = {data[31:8], 8'h80};
         default: res = data;
      endcase
      return res;
   endfunction

endpackage

[sv/sha256_message_hash.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hash
// Streams big-endian message words, pads the final block and returns the
// eight digest words.
// ----------------------------------------------------------------------------
// One request is one 32-bit message word; req_ready is high only while the
// core is idle. A word that does not close a 16-word block is only shifted
// into the schedule. The word that closes a block starts the compression: 64
// rounds at one round per cycle in a single shared round unit, then a final
// step that folds the working variables into the chaining value. After the
// final word the core writes the padding words (marker, zero fill, 64-bit
// length) one per cycle, pausing while a completed block is compressed;
// it compresses one or two more blocks and then offers the eight digest
// words on rsp_*, index 0 first, one per accepted response. The next
// message may start as soon as the eighth word is taken.
module sha256_message_hash
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_digest_index,
   output logic        rsp_digest_last
);

   state_type   state_ff, state_in;
   pad_type     pad_ff, pad_in;
   hash_type    chain_ff, chain_in;
   hash_type    work_ff, work_in;
   sched_type   sched_ff, sched_in;
   logic [3:0]  pos_ff, pos_in;
   logic [5:0]  round_ff, round_in;
   logic [63:0] bit_count_ff, bit_count_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   logic        accept;
   logic [2:0]  nbytes;
   logic [63:0] len_add;
   logic        push;
   word_type    push_word;
   logic        shift;
   word_type    shift_word;
   word_type    new_w;
   word_type    t1;
   word_type    t2;

   assign accept = req_valid & req_ready;

   // Non-final words always count as four bytes
   assign nbytes  = (!req_last || req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
   assign len_add = {58'b0, nbytes, 3'b000};

   // Message schedule and round function
   assign new_w = small_sigma1(sched_ff[14]) + sched_ff[9]
                + small_sigma0(sched_ff[1]) + sched_ff[0];
   assign t1 = work_ff[7] + big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + ROUND_CONST[round_ff] + sched_ff[0];
   assign t2 = big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
               ^ (work_ff[1] & work_ff[2]));

   always_comb begin
      state_in     = state_ff;
      pad_in       = pad_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      pos_in       = pos_ff;
      round_in     = round_ff;
      bit_count_in = bit_count_ff;
      out_idx_in   = out_idx_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      push         = 1'b0;
      push_word    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               push         = 1'b1;
               push_word    = req_last ? mark_word(req_data_word, nbytes) : req_data_word;
               bit_count_in = bit_count_ff + len_add;
               if (req_last) begin
                  state_in = ST_PAD;
                  pad_in   = (nbytes == 3'd4) ? PAD_MARK : PAD_ZERO;
               end
            end
         end
         ST_PAD: begin
            push = 1'b1;
            unique case (pad_ff)
               PAD_MARK: begin
                  push_word = MARK_WORD;
                  pad_in    = PAD_ZERO;
               end
               PAD_ZERO: begin
                  if (pos_ff == LEN_HI_POS) begin
                     push_word = bit_count_ff[63:32];
                     pad_in    = PAD_LEN_LO;
                  end
               end
               PAD_LEN_LO: begin
                  push_word = bit_count_ff[31:0];
                  pad_in    = PAD_DONE;
               end
               default: begin
                  push = 1'b0;
               end
            endcase
         end
         ST_ROUNDS: begin
            for (int k = 7; k > 0; k--) begin
               work_in[k] = work_ff[k-1];
            end
            work_in[4] = work_ff[3] + t1;
            work_in[0] = t1 + t2;
            round_in   = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            for (int k = 0; k < 8; k++) begin
               chain_in[k] = chain_ff[k] + work_ff[k];
            end
            priority if (pad_ff == PAD_NONE) begin
               state_in = ST_IDLE;
            end else if (pad_ff == PAD_DONE) begin
               state_in   = ST_OUT;
               out_idx_in = 3'd0;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  // re-arm for the next message
                  chain_in     = INIT_HASH;
                  bit_count_in = '0;
                  pad_in       = PAD_NONE;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push) begin
         pos_in = pos_ff + 4'd1;
         // closing word of a block: start compression
         if (pos_ff == 4'd15) begin
            state_in = ST_ROUNDS;
            work_in  = chain_ff;
            round_in = 6'd0;
         end
      end
   end

   // Schedule window is a shift line: the word for the current round sits at the head
   assign shift      = push || (state_ff == ST_ROUNDS);
   assign shift_word = push ? push_word : new_w;

   always_comb begin
      sched_in = sched_ff;
      if (shift) begin
         for (int k = 0; k < 15; k++) begin
            sched_in[k] = sched_ff[k+1];
         end
         sched_in[15] = shift_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pad_ff       <= PAD_NONE;
         chain_ff     <= INIT_HASH;
         pos_ff       <= '0;
         round_ff     <= '0;
         bit_count_ff <= '0;
         out_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         pad_ff       <= pad_in;
         chain_ff     <= chain_in;
         pos_ff       <= pos_in;
         round_ff     <= round_in;
         bit_count_ff <= bit_count_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   assign rsp_digest_word  = chain_ff[out_idx_ff];
   assign rsp_digest_index = out_idx_ff;
   assign rsp_digest_last  = (out_idx_ff == 3'd7);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response sides active together");

   a_rounds_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUNDS) |-> (pos_ff == 4'd0))
      else $error("compression running on a partial block");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUNDS && round_ff == 6'd63) |=> (state_ff == ST_FINAL))
      else $error("compression did not end after round 63");

   a_out_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_digest_last)
      |=> (state_ff == ST_IDLE && bit_count_ff == 64'd0 && pos_ff == 4'd0))
      else $error("core not re-armed after digest");

   a_out_padded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pad_ff == PAD_DONE))
      else $error("digest offered before padding finished");

endmodule
